// ===== sv/avcc_pkg.sv =====
// Shared types and constants for the AVC configuration record to Annex B converter.
package avcc_pkg;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Record layout constants
    localparam logic [2:0] HEADER_SKIP    = 3'd5;
    localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;
    localparam logic [2:0] START_CODE_LEN = 3'd4;
    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_OK    = 2'd1,
        KIND_TRUNC = 2'd2
    } kind_t;

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       record_end;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       run_last;
    } out_beat_t;

    // Work descriptor for one input byte; status KIND_DATA means no status beat
    typedef struct packed {
        logic       has_start;
        logic       has_data;
        kind_t      status;
        logic [7:0] data_byte;
    } cmd_t;

endpackage

// ===== sv/avcc_front.sv =====
// Front end: parses the record byte by byte and issues a work descriptor per byte that yields results.
module avcc_front
    import avcc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  in_beat_t s_payload,
    input  logic     s_valid,
    output logic     s_ready,
    output cmd_t     push_cmd,
    output logic     push_valid,
    input  logic     push_ready
);

    typedef enum logic [6:0] {
        PH_SKIP     = 7'b0000001,
        PH_SPSCOUNT = 7'b0000010,
        PH_LENHI    = 7'b0000100,
        PH_LENLO    = 7'b0001000,
        PH_PAYLOAD  = 7'b0010000,
        PH_PPSCOUNT = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  skip_reg, skip_next;
    logic [7:0]  sets_reg, sets_next;
    logic [15:0] payload_reg, payload_next;
    logic [7:0]  lenhi_reg, lenhi_next;
    logic        pics_reg, pics_next;

    logic        fire;
    logic        finish_set;
    logic [2:0]  skip_inc;
    logic [7:0]  sets_dec;
    logic [7:0]  b;
    cmd_t        cmd;

    assign b       = s_payload.in_byte;
    assign s_ready = push_ready;
    assign fire    = s_valid && push_ready;

    // Next state and descriptor for the byte at the input
    always_comb begin
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        sets_next    = sets_reg;
        payload_next = payload_reg;
        lenhi_next   = lenhi_reg;
        pics_next    = pics_reg;
        finish_set   = 1'b0;
        skip_inc     = skip_reg + 3'd1;
        sets_dec     = sets_reg - 8'd1;
        cmd          = '0;
        cmd.data_byte = b;
        cmd.status   = KIND_DATA;

        case (phase_reg)
            PH_SKIP: begin
                if (skip_inc >= HEADER_SKIP) begin
                    skip_next  = 3'd0;
                    phase_next = PH_SPSCOUNT;
                end else begin
                    skip_next = skip_inc;
                end
            end
            PH_SPSCOUNT: begin
                sets_next  = b & SPS_COUNT_MASK;
                pics_next  = 1'b0;
                phase_next = ((b & SPS_COUNT_MASK) == 8'd0) ? PH_PPSCOUNT : PH_LENHI;
            end
            PH_PPSCOUNT: begin
                sets_next = b;
                pics_next = 1'b1;
                if (b == 8'd0) begin
                    phase_next = PH_DONE;
                    cmd.status = KIND_OK;
                end else begin
                    phase_next = PH_LENHI;
                end
            end
            PH_LENHI: begin
                lenhi_next = b;
                phase_next = PH_LENLO;
            end
            PH_LENLO: begin
                payload_next  = {lenhi_reg, b};
                cmd.has_start = 1'b1;
                if ({lenhi_reg, b} == 16'd0) begin
                    finish_set = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                cmd.has_data = 1'b1;
                payload_next = payload_reg - 16'd1;
                finish_set   = (payload_reg == 16'd1);
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        // Current set complete: next set, picture set count, or record done
        if (finish_set) begin
            sets_next = sets_dec;
            if (sets_dec != 8'd0) begin
                phase_next = PH_LENHI;
            end else if (!pics_reg) begin
                phase_next = PH_PPSCOUNT;
            end else begin
                phase_next = PH_DONE;
                cmd.status = KIND_OK;
            end
        end

        // End of record: flag truncation and start over
        if (s_payload.record_end) begin
            if (phase_next != PH_DONE) begin
                cmd.status = KIND_TRUNC;
            end
            phase_next   = PH_SKIP;
            skip_next    = 3'd0;
            sets_next    = 8'd0;
            payload_next = 16'd0;
            lenhi_next   = 8'd0;
            pics_next    = 1'b0;
        end
    end

    // Only bytes that cause results go into the queue
    assign push_cmd   = cmd;
    assign push_valid = s_valid && (cmd.has_start || cmd.has_data || (cmd.status != KIND_DATA));

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SKIP;
            skip_reg    <= 3'd0;
            sets_reg    <= 8'd0;
            payload_reg <= 16'd0;
            lenhi_reg   <= 8'd0;
            pics_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            skip_reg    <= skip_next;
            sets_reg    <= sets_next;
            payload_reg <= payload_next;
            lenhi_reg   <= lenhi_next;
            pics_reg    <= pics_next;
        end
    end

endmodule

// ===== sv/avcc_queue.sv =====
// Small FIFO of work descriptors between the front and back ends.
module avcc_queue
    import avcc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t push_cmd,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_cmd,
    output logic pop_valid,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr, rd;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign wr         = push_valid && push_ready;
    assign rd         = pop && pop_valid;

    // Storage
    always_ff @(posedge aclk) begin
        if (wr) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({wr, rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/avcc_back.sv =====
// Back end: expands each work descriptor into result beats, one per cycle unless stalled.
module avcc_back
    import avcc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      q_cmd,
    input  logic      q_valid,
    output logic      q_pop,
    output out_beat_t m_payload,
    output logic      m_valid,
    input  logic      m_ready
);

    logic [2:0] idx_reg;
    logic [2:0] beat_cnt;
    logic       is_last;
    logic       load;
    out_beat_t  beat;
    out_beat_t  m_payload_reg;
    logic       m_valid_reg;

    // Number of beats this descriptor yields
    assign beat_cnt = (q_cmd.has_start ? START_CODE_LEN : 3'd0)
                    + {2'b00, q_cmd.has_data}
                    + {2'b00, (q_cmd.status != KIND_DATA)};
    assign is_last  = (idx_reg == beat_cnt - 3'd1);
    assign load     = q_valid && (!m_valid_reg || m_ready);
    assign q_pop    = load && is_last;

    // Select the beat at the current index
    always_comb begin
        beat          = '0;
        beat.kind     = KIND_DATA;
        beat.run_last = is_last;
        if (q_cmd.has_start && (idx_reg < START_CODE_LEN)) begin
            beat.out_byte = START_CODE[idx_reg[1:0]];
        end else if (q_cmd.has_data && (idx_reg == 3'd0)) begin
            beat.out_byte = q_cmd.data_byte;
        end else begin
            beat.out_byte = 8'h00;
            beat.kind     = q_cmd.status;
        end
    end

    // Output register and beat index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 3'd0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= is_last ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_payload_reg <= beat;
        end
    end

    assign m_payload = m_payload_reg;
    assign m_valid   = m_valid_reg;

endmodule

// ===== sv/avcc_header_to_annexb_core.sv =====
// Top level of the AVC configuration record to Annex B converter.
//
// Input channel s_*: one record byte per beat, record_end on the last byte.
// Result channel m_*: start code and parameter set bytes (kind data), then
// one status beat (finished or truncated) where the record ends; run_last
// marks the last result caused by one input byte.
// The first result of an input byte passes through the command queue and the
// output register. Payload bytes stream at one byte per cycle while m_ready is
// high. A length-low byte yields four start code beats (five with a status);
// the command queue (QUEUE_DEPTH entries) lets the front keep taking bytes
// meanwhile and deasserts s_ready when full. Header, count and length-high
// bytes give no results unless they carry a status beat.
// Reset (aresetn low, synchronous) returns the parser to the start of a
// record and empties the queue and the output register.
// When the receiver stalls, the output beat holds, the queue fills and then
// s_ready goes low until room frees up.
module avcc_header_to_annexb_core
    import avcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_payload,
    input  logic      s_valid,
    output logic      s_ready,
    output out_beat_t m_payload,
    output logic      m_valid,
    input  logic      m_ready
);

    cmd_t push_cmd, pop_cmd;
    logic push_valid, push_ready;
    logic pop_valid, pop;

    avcc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_payload  (s_payload),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    avcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop)
    );

    avcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_cmd     (pop_cmd),
        .q_valid   (pop_valid),
        .q_pop     (pop),
        .m_payload (m_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule

// ===== sv/avcc_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module avcc_checker
    import avcc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input in_beat_t  s_payload,
    input logic      s_valid,
    input logic      s_ready,
    input out_beat_t m_payload,
    input logic      m_valid,
    input logic      m_ready
);

    // Stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("input beat changed while stalled");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // A status beat always closes the run of one input byte
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind != KIND_DATA) |-> m_payload.run_last)
        else $error("status beat without run_last");

    // Status beats carry a zero byte
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.kind != KIND_DATA) |-> (m_payload.out_byte == 8'h00))
        else $error("status beat with nonzero byte");

    // Beats of one run follow without a gap
    a_run_dense: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.run_last |=> m_valid)
        else $error("gap inside a run of results");

endmodule

bind avcc_header_to_annexb_core avcc_checker u_avcc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_payload (s_payload),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_payload (m_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready)
);
